// ----- rtl/ili_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ili_pkg: shared types and codes for the indexed list
// Request and response beats, function and status codes, cell commands.
// ----------------------------------------------------------------------------
package ili_pkg;

  // request function codes
  localparam logic [2:0] FN_READ   = 3'd0;
  localparam logic [2:0] FN_HEAD   = 3'd1;
  localparam logic [2:0] FN_TAIL   = 3'd2;
  localparam logic [2:0] FN_AT     = 3'd3;
  localparam logic [2:0] FN_DELETE = 3'd4;

  // response status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         func;
    logic [6:0]         position;
    logic signed [31:0] value;
  } req_item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [6:0]         count;
  } rsp_item_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE
  } cell_op_e;

  typedef struct packed {
    cell_op_e    op;
    logic [31:0] value;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REDUCE,
    S_DELIVER
  } ctl_state_e;

endpackage

// ----- rtl/ili_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ili_cell: one list slot
// Holds one entry; takes its left or right neighbor on insert or delete.
// ----------------------------------------------------------------------------
module ili_cell #(
  parameter int IDX = 0,
  parameter int PW  = 7
) (
  input  logic              clk,
  input  ili_pkg::cell_cmd_t cmd,
  input  logic [PW-1:0]     pos,
  input  logic [31:0]       left,
  input  logic [31:0]       right,
  output logic [31:0]       data,
  output logic [31:0]       hit
);
  import ili_pkg::*;

  logic at_pos;
  logic past_pos;

  assign at_pos   = (PW'(IDX) == pos);
  assign past_pos = (PW'(IDX) > pos);

  // masked copy for the read reduction
  assign hit = at_pos ? data : '0;

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      CELL_INSERT: begin
        if (at_pos) begin
          data <= cmd.value;
        end else if (past_pos) begin
          data <= left;
        end
      end
      CELL_DELETE: begin
        if (at_pos || past_pos) begin
          data <= right;
        end
      end
      default: begin
        data <= data;
      end
    endcase
  end

endmodule

// ----- rtl/ili_or_reduce.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ili_or_reduce: registered four-input or tree
// Collects the one selected cell word, one level a cycle while step is high.
// ----------------------------------------------------------------------------
module ili_or_reduce #(
  parameter int N = 64
) (
  input  logic        clk,
  input  logic        load,
  input  logic        step,
  input  logic [31:0] leaf [N],
  output logic [31:0] result
);
  import ili_pkg::*;

  logic [31:0] node [N];

  for (genvar j = 0; j < N; j++) begin : g_node
    logic [31:0] part [4];
    for (genvar k = 0; k < 4; k++) begin : g_part
      if (4 * j + k < N) begin : g_in
        assign part[k] = node[4 * j + k];
      end else begin : g_zero
        assign part[k] = '0;
      end
    end

    always_ff @(posedge clk) begin
      if (load) begin
        node[j] <= leaf[j];
      end else if (step) begin
        node[j] <= part[0] | part[1] | part[2] | part[3];
      end
    end
  end

  assign result = node[0];

endmodule

// ----- rtl/indexed_list_insert_delete.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_insert_delete: ordered list with indexed insert and delete
// A row of cells holds the list; one read, insert or delete per request.
// ----------------------------------------------------------------------------
//   channel  | direction | beat        | handshake
//   req      | in        | req_item_t  | req_valid / req_stall
//   rsp      | out       | rsp_item_t  | rsp_valid / rsp_stall
//
// the registered or tree that picks the read word has LEVELS levels,
// LEVELS = ceil(log4(CAPACITY))
// inserts and deletes shift the cells at and past the position in the accept cycle
// a finished response waits in the output register; the next request is taken
// meanwhile, and its response waits for the previous one to leave
// reset clears the count and the control; cell contents are not reset
// ----------------------------------------------------------------------------
module indexed_list_insert_delete #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  ili_pkg::req_item_t req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output ili_pkg::rsp_item_t rsp
);
  import ili_pkg::*;

  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int PW     = (CW > 7) ? CW : 7;
  localparam int LEVELS = ($clog2(CAPACITY) + 1) / 2;
  localparam int LW     = $clog2(LEVELS + 1);

  ctl_state_e    state, state_next;
  logic [LW-1:0] lvl, lvl_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [1:0]    st_q;
  logic          hit_q;

  logic          accept;
  logic          full;
  logic          rsp_load;
  logic [PW-1:0] pos_w;
  logic [PW-1:0] cnt_w;
  logic [PW-1:0] cell_pos;
  logic [1:0]    dec_st;
  logic          dec_hit;
  cell_op_e      dec_op;
  cell_cmd_t     cmd;

  logic [31:0]   cell_data [CAPACITY];
  logic [31:0]   cell_hit [CAPACITY];
  logic [31:0]   red_out;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);
  assign pos_w     = PW'(req.position);
  assign cnt_w     = PW'(cnt);
  assign full      = (cnt_w == PW'(CAPACITY));

  // request decode against the current count
  always_comb begin
    dec_op   = CELL_HOLD;
    dec_st   = ST_DONE;
    dec_hit  = 1'b0;
    cell_pos = pos_w;
    cnt_next = cnt;
    unique case (req.func)
      FN_READ: begin
        if (pos_w < cnt_w) begin
          dec_hit = 1'b1;
        end else begin
          dec_st = ST_RANGE;
        end
      end
      FN_HEAD: begin
        cell_pos = '0;
        if (full) begin
          dec_st = ST_FULL;
        end else begin
          dec_op   = CELL_INSERT;
          cnt_next = cnt + CW'(1);
        end
      end
      FN_TAIL: begin
        cell_pos = cnt_w;
        if (full) begin
          dec_st = ST_FULL;
        end else begin
          dec_op   = CELL_INSERT;
          cnt_next = cnt + CW'(1);
        end
      end
      FN_AT: begin
        if (pos_w > cnt_w) begin
          dec_st = ST_RANGE;
        end else if (full) begin
          dec_st = ST_FULL;
        end else begin
          dec_op   = CELL_INSERT;
          cnt_next = cnt + CW'(1);
        end
      end
      FN_DELETE: begin
        if (pos_w >= cnt_w) begin
          dec_st = ST_RANGE;
        end else begin
          dec_op   = CELL_DELETE;
          cnt_next = cnt - CW'(1);
        end
      end
      default: begin
        dec_st = ST_DONE;
      end
    endcase
  end

  assign cmd.op    = accept ? dec_op : CELL_HOLD;
  assign cmd.value = req.value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [31:0] left;
    logic [31:0] right;
    if (i == 0) begin : g_head
      assign left = '0;
    end else begin : g_left
      assign left = cell_data[i - 1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right = '0;
    end else begin : g_right
      assign right = cell_data[i + 1];
    end

    ili_cell #(
      .IDX (i),
      .PW  (PW)
    ) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .pos   (cell_pos),
      .left  (left),
      .right (right),
      .data  (cell_data[i]),
      .hit   (cell_hit[i])
    );
  end

  ili_or_reduce #(
    .N (CAPACITY)
  ) u_reduce (
    .clk    (clk),
    .load   (accept),
    .step   (state == S_REDUCE),
    .leaf   (cell_hit),
    .result (red_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      lvl   <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      lvl   <= lvl_next;
      if (accept) begin
        cnt <= cnt_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_q  <= dec_st;
      hit_q <= dec_hit;
    end
  end

  always_comb begin
    state_next = state;
    lvl_next   = lvl;
    rsp_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_REDUCE;
          lvl_next   = LW'(LEVELS - 1);
        end
      end
      S_REDUCE: begin
        if (lvl == '0) begin
          state_next = S_DELIVER;
        end else begin
          lvl_next = lvl - LW'(1);
        end
      end
      S_DELIVER: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.read_value <= hit_q ? red_out : '1;
      rsp.status     <= st_q;
      rsp.count      <= cnt_w[6:0];
    end
  end

`ifndef ASSERT_OFF
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    cnt_w <= PW'(CAPACITY))
    else $error("entry count above capacity");

  a_full_holds : assert property (@(posedge clk) disable iff (rst)
    (accept && full && (req.func == FN_HEAD || req.func == FN_TAIL ||
     req.func == FN_AT)) |=> (cnt == $past(cnt)))
    else $error("insert into full list changed the count");

  a_miss_word : assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != ST_DONE) |-> (rsp.read_value == '1))
    else $error("failed request returned a read value");

  a_start_reduce : assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_REDUCE))
    else $error("accepted request did not start the read reduction");
`endif

endmodule
